// File: rtl/b64sc_pkg.sv
// Shared types, constants and alphabet functions for the base64 stream codec.
`default_nettype none

package b64sc_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  count;
    logic [1:0]  pads;
  } b64sc_group_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
    logic            err;
  } b64sc_burst_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    c = {2'b00, v};
    if (v < 6'd26) begin
      sextet_char = 8'h41 + c;
    end else if (v < 6'd52) begin
      sextet_char = 8'h61 + c - 8'd26;
    end else if (v < 6'd62) begin
      sextet_char = 8'h30 + c - 8'd52;
    end else if (v == 6'd62) begin
      sextet_char = 8'h2B;
    end else begin
      sextet_char = 8'h2F;
    end
  endfunction

  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end
    char_value = d[5:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64sc_if.sv
// Handshake interfaces for the item, result and configuration channels.
`default_nettype none

interface b64sc_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64sc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       length_error;
  modport source (output valid, output out_byte, output out_last, output length_error,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input length_error,
                output ready);
endinterface

interface b64sc_cfg_if;
  logic valid;
  logic ready;
  logic decode_mode;
  modport source (output valid, output decode_mode, input ready);
  modport sink (input valid, input decode_mode, output ready);
endinterface

`default_nettype wire

// File: rtl/base64_stream_codec_core.sv
// Top level of the base64 stream codec: group state, result buffer and handshakes.
//
//   channel  dir  payload                             accepted when
//   items    in   in_byte[7:0], in_last               items.valid & items.ready
//   results  out  out_byte[7:0], out_last, length_error  results.valid & results.ready
//   cfg      in   decode_mode                         cfg.valid & cfg.ready
//
// An item is processed in the cycle it is accepted; its results (0 to 4) are
// registered and leave one per cycle unless results stall. A new item is taken
// while the last result of the previous burst goes out.
// Reset clears the mode (encode), the group state and the result buffer.
// A stall on results holds the buffer and blocks items unless the buffer is empty
// or its last result leaves in that cycle.
`default_nettype none

module base64_stream_codec_core
  import b64sc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  b64sc_item_if.sink     items,
  b64sc_result_if.source results,
  b64sc_cfg_if.sink      cfg
);

  logic            decode_mode;
  b64sc_group_t    group;
  b64sc_group_t    group_next;
  b64sc_burst_t    burst;
  logic [3:0][7:0] obuf_bytes;
  logic [2:0]      obuf_n;
  logic [1:0]      obuf_idx;
  logic            obuf_last;
  logic            obuf_err;
  logic            take;
  logic            accept;

  b64sc_step u_step (
    .decode_mode (decode_mode),
    .group       (group),
    .in_byte     (items.in_byte),
    .in_last     (items.in_last),
    .group_next  (group_next),
    .burst       (burst)
  );

  assign take         = results.valid && results.ready;
  assign items.ready  = (obuf_n == 3'd0) || (obuf_n == 3'd1 && results.ready);
  assign accept       = items.valid && items.ready;
  assign cfg.ready    = 1'b1;

  assign results.valid        = obuf_n != 3'd0;
  assign results.out_byte     = obuf_bytes[obuf_idx];
  assign results.out_last     = obuf_last && obuf_n == 3'd1;
  assign results.length_error = obuf_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      group       <= '0;
      obuf_n      <= 3'd0;
      obuf_idx    <= 2'd0;
      obuf_last   <= 1'b0;
      obuf_err    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        decode_mode <= cfg.decode_mode;
        group       <= '0;
      end else if (accept) begin
        group <= group_next;
      end
      if (accept && burst.count != 3'd0) begin
        obuf_bytes <= burst.bytes;
        obuf_n     <= burst.count;
        obuf_idx   <= 2'd0;
        obuf_last  <= burst.last;
        obuf_err   <= burst.err;
      end else if (take) begin
        obuf_n   <= obuf_n - 3'd1;
        obuf_idx <= obuf_idx + 2'd1;
      end
    end
  end

  a_ready_only_near_empty: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> obuf_n <= 3'd1)
    else $error("item accepted while result buffer busy");

  a_error_result_form: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.length_error |-> results.out_byte == 8'd0 && results.out_last)
    else $error("length error result malformed");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("results valid after reset");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    obuf_n <= 3'd4 && (!obuf_err || obuf_n <= 3'd1))
    else $error("result buffer count out of range");

endmodule

`default_nettype wire

// File: rtl/b64sc_step.sv
// Per-item group update and result burst generation for encode and decode.
`default_nettype none

module b64sc_step
  import b64sc_pkg::*;
(
  input  wire logic         decode_mode,
  input  wire b64sc_group_t group,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  output b64sc_group_t      group_next,
  output b64sc_burst_t      burst
);

  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic [5:0]  value;
  logic [1:0]  pads;
  logic [1:0]  n_bytes;

  always_comb begin
    case (group.count)
      2'd0:    enc_bits = {in_byte, group.bits[15:0]};
      2'd1:    enc_bits = {group.bits[23:16], in_byte, group.bits[7:0]};
      default: enc_bits = {group.bits[23:8], in_byte};
    endcase
  end

  assign value = char_value(in_byte);

  always_comb begin
    case (group.count)
      2'd0:    dec_bits = group.bits | {value, 18'd0};
      2'd1:    dec_bits = group.bits | {6'd0, value, 12'd0};
      2'd2:    dec_bits = group.bits | {12'd0, value, 6'd0};
      default: dec_bits = group.bits | {18'd0, value};
    endcase
  end

  always_comb begin
    pads = group.pads;
    if (in_byte == PAD_CHAR && group.count[1] && group.pads != 2'd2) begin
      pads = group.pads + 2'd1;
    end
    n_bytes = 2'd3 - pads;
  end

  always_comb begin
    group_next = '0;
    burst      = '0;
    if (!decode_mode) begin
      if (group.count != 2'd0 && group.count != 2'd1 || in_last) begin
        burst.count    = 3'd4;
        burst.last     = in_last;
        burst.bytes[0] = sextet_char(enc_bits[23:18]);
        burst.bytes[1] = sextet_char(enc_bits[17:12]);
        burst.bytes[2] = (group.count != 2'd0) ? sextet_char(enc_bits[11:6]) : PAD_CHAR;
        burst.bytes[3] = (group.count[1]) ? sextet_char(enc_bits[5:0]) : PAD_CHAR;
      end else begin
        group_next.bits  = enc_bits;
        group_next.count = group.count + 2'd1;
      end
    end else begin
      if (group.count == 2'd3) begin
        burst.count    = {1'b0, n_bytes};
        burst.last     = in_last;
        burst.bytes[0] = dec_bits[23:16];
        burst.bytes[1] = dec_bits[15:8];
        burst.bytes[2] = dec_bits[7:0];
      end else if (in_last) begin
        burst.count = 3'd1;
        burst.last  = 1'b1;
        burst.err   = 1'b1;
      end else begin
        group_next.bits  = dec_bits;
        group_next.count = group.count + 2'd1;
        group_next.pads  = pads;
      end
    end
  end

endmodule

`default_nettype wire
